// ===== rtl/core/bs3_pkg.sv =====
// ----------------------------------------------------------------------------
// bs3_pkg
// shared constants and types for the 3d box window sum
// ----------------------------------------------------------------------------
package bs3_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WINDOW);
  localparam int ZW   = 17;
  localparam int RW   = SAMPLE_BITS + WW;
  localparam int CW   = RW + WW;
  localparam int PW   = CW + WW;
  localparam int OUTW = 28;

  localparam logic [2:0] REG_IN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_IN_DEPTH  = 3'd2;
  localparam logic [2:0] REG_WIN_X     = 3'd3;
  localparam logic [2:0] REG_WIN_Y     = 3'd4;
  localparam logic [2:0] REG_WIN_Z     = 3'd5;

  typedef struct packed {
    logic [XW:0]   iw;
    logic [YW:0]   ih;
    logic [ZW-1:0] id;
    logic [WW:0]   wx;
    logic [WW:0]   wy;
    logic [WW:0]   wz;
    logic [XW:0]   ow;
    logic [YW:0]   oh;
    logic [ZW-1:0] od;
  } geom_t;

  // per request position info carried down the pipe
  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [ZW-1:0] z;
    logic          row_end;
    logic          vol_end;
  } pos_t;

endpackage

// ===== rtl/core/bs3_cfg.sv =====
// ----------------------------------------------------------------------------
// bs3_cfg
// register file and clamped geometry
// ----------------------------------------------------------------------------
module bs3_cfg import bs3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        restart,
  output geom_t       geom
);

  logic [8:0]  in_width, in_height;
  logic [15:0] in_depth;
  logic [4:0]  win_x, win_y, win_z;
  logic        wr;
  logic [2:0]  idx;
  logic [9:0]  ow_raw, oh_raw;
  logic [4:0]  wxc, wyc, wzc;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  // restart lands on the same edge as the register write
  assign restart = wr && (idx <= REG_WIN_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width <= 9'd1; in_height <= 9'd1; in_depth <= 16'd1;
      win_x <= 5'd1; win_y <= 5'd1; win_z <= 5'd1;
    end else begin
      if (wr) begin
        case (idx)
          REG_IN_WIDTH:  in_width  <= pwdata[8:0];
          REG_IN_HEIGHT: in_height <= pwdata[8:0];
          REG_IN_DEPTH:  in_depth  <= pwdata[15:0];
          REG_WIN_X:     win_x     <= pwdata[4:0];
          REG_WIN_Y:     win_y     <= pwdata[4:0];
          REG_WIN_Z:     win_z     <= pwdata[4:0];
          default:       ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_IN_WIDTH:  prdata = {23'd0, in_width};
      REG_IN_HEIGHT: prdata = {23'd0, in_height};
      REG_IN_DEPTH:  prdata = {16'd0, in_depth};
      REG_WIN_X:     prdata = {27'd0, win_x};
      REG_WIN_Y:     prdata = {27'd0, win_y};
      REG_WIN_Z:     prdata = {27'd0, win_z};
      default:       prdata = 32'd0;
    endcase
  end

  always_comb begin
    wxc = (win_x == 5'd0) ? 5'd1 : (win_x > 5'd16) ? 5'd16 : win_x;
    wyc = (win_y == 5'd0) ? 5'd1 : (win_y > 5'd16) ? 5'd16 : win_y;
    wzc = (win_z == 5'd0) ? 5'd1 : (win_z > 5'd16) ? 5'd16 : win_z;
    geom.iw = (in_width == 9'd0) ? 9'd1 : (in_width > 9'd256) ? 9'd256 : in_width;
    geom.ih = (in_height == 9'd0) ? 9'd1 : (in_height > 9'd256) ? 9'd256 : in_height;
    geom.id = (in_depth == 16'd0) ? 17'd1 : {1'b0, in_depth};
    geom.wx = wxc;
    geom.wy = wyc;
    geom.wz = wzc;
    ow_raw = {1'b0, geom.iw} + {5'd0, wxc} - 10'd1;
    oh_raw = {1'b0, geom.ih} + {5'd0, wyc} - 10'd1;
    geom.ow = (ow_raw > 10'd256) ? 9'd256 : ow_raw[8:0];
    geom.oh = (oh_raw > 10'd256) ? 9'd256 : oh_raw[8:0];
    geom.od = geom.id + {12'd0, wzc} - 17'd1;
  end

endmodule

// ===== rtl/core/bs3_row.sv =====
// ----------------------------------------------------------------------------
// bs3_row
// raster position tracking and running row sum over the recent samples
// ----------------------------------------------------------------------------
module bs3_row import bs3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  geom_t                  geom,
  input  logic                   in_fire,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   r_valid,
  output logic [RW-1:0]          r_sum,
  output pos_t                   r_pos
);

  logic [XW:0]   pos_x;
  logic [YW:0]   pos_y;
  logic [ZW-1:0] pos_z;
  logic [SAMPLE_BITS-1:0] recent [MAX_WINDOW];
  logic [RW-1:0] run;
  logic [XW:0]   x;
  logic [YW:0]   y;
  logic [ZW-1:0] z;
  logic [SAMPLE_BITS-1:0] s, leaving;
  logic          in_ext, re, ye, ze;
  logic [RW-1:0] run_next;

  always_comb begin
    x = (pos_x >= geom.ow) ? '0 : pos_x;
    y = (pos_y >= geom.oh) ? '0 : pos_y;
    z = (pos_z >= geom.od) ? '0 : pos_z;
    in_ext = (x < geom.iw) && (y < geom.ih) && (z < geom.id);
    s = in_ext ? sample : '0;
    leaving = (x == '0) ? '0 : recent[WW'(geom.wx - 1'b1)];
    run_next = ((x == '0) ? '0 : run) + RW'(s) - RW'(leaving);
    re = (x == geom.ow - 1'b1);
    ye = (y == geom.oh - 1'b1);
    ze = (z == geom.od - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
      r_valid <= 1'b0;
      run <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) recent[i] <= '0;
    end else begin
      r_valid <= in_fire;
      if (in_fire) begin
        for (int i = 1; i < MAX_WINDOW; i++)
          recent[i] <= (x == '0) ? '0 : recent[i-1];
        recent[0] <= s;
        run <= run_next;
        r_sum <= run_next;
        r_pos.x <= x[XW-1:0];
        r_pos.y <= y[YW-1:0];
        r_pos.z <= z;
        r_pos.row_end <= re;
        r_pos.vol_end <= re && ye && ze;
        if (!re) begin
          pos_x <= x + 1'b1;
          pos_y <= y;
          pos_z <= z;
        end else begin
          pos_x <= '0;
          if (!ye) begin
            pos_y <= y + 1'b1;
            pos_z <= z;
          end else begin
            pos_y <= '0;
            pos_z <= ze ? '0 : z + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/bs3_col.sv =====
// ----------------------------------------------------------------------------
// bs3_col
// column sums: row history memory plus per-column running sums
// ----------------------------------------------------------------------------
module bs3_col import bs3_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  geom_t         geom,
  input  logic          r_valid,
  input  logic [RW-1:0] r_sum,
  input  pos_t          r_pos,
  output logic          c_valid,
  output logic [CW-1:0] c_sum,
  output pos_t          c_pos
);

  logic [RW-1:0] hist [MAX_WINDOW*MAX_WIDTH];
  logic [CW-1:0] csum [MAX_WIDTH];
  logic [RW-1:0] hist_q;
  logic [CW-1:0] csum_q;
  logic          v1;
  logic [RW-1:0] r1;
  pos_t          p1;
  logic          use_old, use_prev;
  logic [YW-1:0] yold;
  logic [CW-1:0] c_new;
  // forwarding of last write (same column only when width is one)
  logic          fw_v;
  logic [XW-1:0] fw_x;
  logic [CW-1:0] fw_c;
  // row history read hitting the entry written on the same edge
  logic          hit_old;
  logic [RW-1:0] fw_r;

  assign yold = r_pos.y - YW'(geom.wy);

  always_ff @(posedge clk) begin
    hist_q <= hist[{yold[WW-1:0], r_pos.x}];
    csum_q <= csum[r_pos.x];
    r1 <= r_sum;
    p1 <= r_pos;
    use_old  <= ({1'b0, r_pos.y} >= (YW+1)'(geom.wy));
    use_prev <= (r_pos.y != '0);
    hit_old  <= v1 && ({p1.y[WW-1:0], p1.x} == {yold[WW-1:0], r_pos.x});
    fw_r     <= r1;
    if (v1) begin
      hist[{p1.y[WW-1:0], p1.x}] <= r1;
      csum[p1.x] <= c_new;
    end
  end

  always_comb begin
    logic [CW-1:0] prev;
    logic [RW-1:0] rold;
    prev = (fw_v && fw_x == p1.x) ? fw_c : csum_q;
    rold = hit_old ? fw_r : hist_q;
    c_new = (use_prev ? prev : '0) + CW'(r1) - (use_old ? CW'(rold) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      v1 <= 1'b0; c_valid <= 1'b0; fw_v <= 1'b0;
    end else begin
      v1 <= r_valid;
      c_valid <= v1;
      fw_v <= v1;
    end
    fw_x <= p1.x;
    fw_c <= c_new;
    c_sum <= c_new;
    c_pos <= p1;
  end

endmodule

// ===== rtl/core/bs3_plane.sv =====
// ----------------------------------------------------------------------------
// bs3_plane
// plane sums: column history memory plus per-position running sums
// ----------------------------------------------------------------------------
module bs3_plane import bs3_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  geom_t         geom,
  input  logic          c_valid,
  input  logic [CW-1:0] c_sum,
  input  pos_t          c_pos,
  output logic          p_valid,
  output logic [PW-1:0] p_sum,
  output pos_t          p_pos
);

  localparam int AW = XW + YW;

  logic [CW-1:0] chist [MAX_WINDOW*MAX_HEIGHT*MAX_WIDTH];
  logic [PW-1:0] psum  [MAX_HEIGHT*MAX_WIDTH];
  logic [CW-1:0] chist_q;
  logic [PW-1:0] psum_q;
  logic          v1, use_old, use_prev;
  logic [CW-1:0] c1;
  pos_t          p1;
  logic [ZW-1:0] zold;
  logic [PW-1:0] p_new;
  logic          fw_v;
  logic [AW-1:0] fw_a;
  logic [PW-1:0] fw_p;
  // column history read hitting the entry written on the same edge
  logic          hit_old;
  logic [CW-1:0] fw_ch;

  assign zold = c_pos.z - ZW'(geom.wz);

  always_ff @(posedge clk) begin
    chist_q <= chist[{zold[WW-1:0], c_pos.y, c_pos.x}];
    psum_q  <= psum[{c_pos.y, c_pos.x}];
    c1 <= c_sum;
    p1 <= c_pos;
    use_old  <= (c_pos.z >= ZW'(geom.wz));
    use_prev <= (c_pos.z != '0);
    hit_old  <= v1 && ({p1.z[WW-1:0], p1.y, p1.x} ==
                       {zold[WW-1:0], c_pos.y, c_pos.x});
    fw_ch    <= c1;
    if (v1) begin
      chist[{p1.z[WW-1:0], p1.y, p1.x}] <= c1;
      psum[{p1.y, p1.x}] <= p_new;
    end
  end

  always_comb begin
    logic [PW-1:0] prev;
    logic [CW-1:0] cold;
    prev = (fw_v && fw_a == {p1.y, p1.x}) ? fw_p : psum_q;
    cold = hit_old ? fw_ch : chist_q;
    p_new = (use_prev ? prev : '0) + PW'(c1) - (use_old ? PW'(cold) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      v1 <= 1'b0; p_valid <= 1'b0; fw_v <= 1'b0;
    end else begin
      v1 <= c_valid;
      p_valid <= v1;
      fw_v <= v1;
    end
    fw_a <= {p1.y, p1.x};
    fw_p <= p_new;
    p_sum <= p_new;
    p_pos <= p1;
  end

endmodule

// ===== rtl/core/box_sum_3d_full.sv =====
// ----------------------------------------------------------------------------
// box_sum_3d_full
// streaming full 3d box window sum
// ----------------------------------------------------------------------------
// channel   dir  content
// s_axis    in   tdata[15:0] sample
// m_axis    out  tdata[27:0] window_sum, tuser[1:0] {volume_end, row_end}
// apb       in   six geometry and window registers at 4*i
// one request per cycle while s_axis_tready is high; a result is offered once
// its request has passed the row stage, two memory stages each for column and
// plane passes and the output fifo. a fifo of 8 entries keeps all requests in
// flight when m_axis stalls; s_axis_tready drops while 8 requests are in
// flight. reset clears positions and pipe valids; history memories need no
// clearing since every read entry is written first in the volume.
// ----------------------------------------------------------------------------
module box_sum_3d_full import bs3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // window_sum, zero fill
  output logic [1:0]  m_axis_tuser,   // volume_end, row_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FD = 8;
  localparam int FA = $clog2(FD);

  geom_t geom;
  logic  restart, in_fire;
  logic  r_valid, c_valid, p_valid;
  logic [RW-1:0] r_sum;
  logic [CW-1:0] c_sum;
  logic [PW-1:0] p_sum;
  pos_t  r_pos, c_pos, p_pos;

  logic [OUTW+1:0] fifo [FD];
  logic [FA-1:0]   wp, rp;
  logic [FA:0]     cnt, inflight;
  logic            out_fire;

  assign pready = 1'b1;

  bs3_cfg u_cfg (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
                 .prdata, .restart, .geom);

  bs3_row u_row (.clk, .rst, .restart, .geom, .in_fire,
                 .sample(s_axis_tdata), .r_valid, .r_sum, .r_pos);

  bs3_col u_col (.clk, .rst, .restart, .geom, .r_valid, .r_sum, .r_pos,
                 .c_valid, .c_sum, .c_pos);

  bs3_plane u_pl (.clk, .rst, .restart, .geom, .c_valid, .c_sum, .c_pos,
                  .p_valid, .p_sum, .p_pos);

  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (inflight < (FA+1)'(FD));
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt != '0);
  assign m_axis_tdata = {{(32-OUTW){1'b0}}, fifo[rp][OUTW-1:0]};
  assign m_axis_tuser = fifo[rp][OUTW+1:OUTW];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; inflight <= '0;
    end else begin
      if (p_valid) wp <= wp + 1'b1;
      if (out_fire) rp <= rp + 1'b1;
      cnt <= cnt + (FA+1)'(p_valid) - (FA+1)'(out_fire);
      inflight <= inflight + (FA+1)'(in_fire) - (FA+1)'(out_fire);
    end
    if (p_valid)
      fifo[wp] <= {p_pos.vol_end, p_pos.row_end, p_sum[OUTW-1:0]};
  end

endmodule

// ===== sim/tb_box_sum_3d_full.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_sum_3d_full
// self-checking testbench for the streaming 3d box window sum
// ----------------------------------------------------------------------------
// programs volume extents and window lengths over apb, streams one sample per
// output raster position and checks every window sum, row end and volume end
// against a behavioral model of the running row, column and plane sums. both
// stream sides stall at random; geometry changes only while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_box_sum_3d_full;
  import bs3_pkg::*;

  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [OUTW-1:0] window_sum;
    logic            row_end;
    logic            volume_end;
  } sum_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // window_sum, zero fill
  logic [1:0]  m_axis_tuser;   // volume_end, row_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  box_sum_3d_full uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // geometry registers and running state of the model
  logic [8:0]  cfg_in_width, cfg_in_height;
  logic [15:0] cfg_in_depth;
  logic [4:0]  cfg_win_x, cfg_win_y, cfg_win_z;
  int unsigned cur_x, cur_y, cur_z;
  longint unsigned recent_smp [MAX_WINDOW];
  longint unsigned row_run;
  longint unsigned row_hist [int];
  longint unsigned col_sum [int];
  longint unsigned col_hist [int];
  longint unsigned plane_acc [int];

  sum_result_t expected_sums [$];
  int          errors;
  bit          rx_stall_on;
  bit          tx_stall_on;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic void restart_volume();
    cur_x = 0;
    cur_y = 0;
    cur_z = 0;
    foreach (recent_smp[i]) recent_smp[i] = 0;
    row_run = 0;
  endfunction

  function automatic sum_result_t predict_window_sum(logic [15:0] smp);
    int unsigned iw, ih, id, wx, wy, wz, ow, oh, od, x, y, z, pidx, k;
    longint unsigned s, leaving, r, cprev, rold, c, pprev, cold, p;
    sum_result_t res;
    iw = clampu(cfg_in_width, 1, MAX_WIDTH);
    ih = clampu(cfg_in_height, 1, MAX_HEIGHT);
    id = (cfg_in_depth == 0) ? 1 : cfg_in_depth;
    wx = clampu(cfg_win_x, 1, MAX_WINDOW);
    wy = clampu(cfg_win_y, 1, MAX_WINDOW);
    wz = clampu(cfg_win_z, 1, MAX_WINDOW);
    ow = clampu(iw + wx - 1, 1, MAX_WIDTH);
    oh = clampu(ih + wy - 1, 1, MAX_HEIGHT);
    od = id + wz - 1;
    x = (cur_x >= ow) ? 0 : cur_x;
    y = (cur_y >= oh) ? 0 : cur_y;
    z = (cur_z >= od) ? 0 : cur_z;
    s = (x < iw && y < ih && z < id) ? smp : 0;
    if (x == 0) begin
      foreach (recent_smp[i]) recent_smp[i] = 0;
      row_run = 0;
    end
    leaving = recent_smp[wx-1];
    for (k = MAX_WINDOW - 1; k > 0; k--) recent_smp[k] = recent_smp[k-1];
    recent_smp[0] = s;
    row_run = row_run + s - leaving;
    r = row_run;
    cprev = (y == 0) ? 0 : (col_sum.exists(x) ? col_sum[x] : 0);
    k = ((y - wy) % MAX_WINDOW) * MAX_WIDTH + x;
    rold = (y >= wy && row_hist.exists(k)) ? row_hist[k] : 0;
    c = cprev + r - rold;
    row_hist[(y % MAX_WINDOW) * MAX_WIDTH + x] = r;
    col_sum[x] = c;
    pidx = y * MAX_WIDTH + x;
    pprev = (z == 0) ? 0 : (plane_acc.exists(pidx) ? plane_acc[pidx] : 0);
    k = ((z - wz) % MAX_WINDOW) * (MAX_HEIGHT * MAX_WIDTH) + pidx;
    cold = (z >= wz && col_hist.exists(k)) ? col_hist[k] : 0;
    p = pprev + c - cold;
    col_hist[(z % MAX_WINDOW) * (MAX_HEIGHT * MAX_WIDTH) + pidx] = c;
    plane_acc[pidx] = p;
    res.window_sum = p[OUTW-1:0];
    res.row_end    = (x == ow - 1);
    res.volume_end = res.row_end && (y == oh - 1) && (z == od - 1);
    if (!res.row_end) begin
      x++;
    end else begin
      x = 0;
      if (y < oh - 1) begin
        y++;
      end else begin
        y = 0;
        z = (z < od - 1) ? z + 1 : 0;
      end
    end
    cur_x = x;
    cur_y = y;
    cur_z = z;
    return res;
  endfunction

  function automatic int unsigned raster_size();
    int unsigned wx, wy;
    wx = clampu(cfg_win_x, 1, MAX_WINDOW);
    wy = clampu(cfg_win_y, 1, MAX_WINDOW);
    return clampu(clampu(cfg_in_width, 1, MAX_WIDTH) + wx - 1, 1, MAX_WIDTH)
         * clampu(clampu(cfg_in_height, 1, MAX_HEIGHT) + wy - 1, 1, MAX_HEIGHT)
         * (((cfg_in_depth == 0) ? 1 : cfg_in_depth) + clampu(cfg_win_z, 1, MAX_WINDOW) - 1);
  endfunction

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned act_v);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0h actual %0h at %0t", what, exp_v, act_v, $realtime);
  endtask

  task automatic wait_drained();
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] mask;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    mask = 0;
    case (idx)
      REG_IN_WIDTH:  begin cfg_in_width  = val[8:0];  mask = 32'h1ff; end
      REG_IN_HEIGHT: begin cfg_in_height = val[8:0];  mask = 32'h1ff; end
      REG_IN_DEPTH:  begin cfg_in_depth  = val[15:0]; mask = 32'hffff; end
      REG_WIN_X:     begin cfg_win_x     = val[4:0];  mask = 32'h1f; end
      REG_WIN_Y:     begin cfg_win_y     = val[4:0];  mask = 32'h1f; end
      REG_WIN_Z:     begin cfg_win_z     = val[4:0];  mask = 32'h1f; end
      default: ;
    endcase
    if (mask == 0) return;
    restart_volume();
    // read back
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) != (val & mask)) report_mismatch("readback", val & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned d,
                              int unsigned wx, int unsigned wy, int unsigned wz);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_IN_DEPTH, d);
    write_reg(REG_WIN_X, wx);
    write_reg(REG_WIN_Y, wy);
    write_reg(REG_WIN_Z, wz);
  endtask

  task automatic send_sample(logic [15:0] smp);
    int unsigned gap;
    gap = tx_stall_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk); while (!s_axis_tready);
    expected_sums.push_back(predict_window_sum(smp));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'hffff;
      1: return 16'h0000;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // full small volume with extreme samples, zero on every third
  task automatic test_directed_volume();
    set_geometry(2, 2, 1, 2, 2, 2);
    for (int i = 0; i < 18; i++) send_sample((i % 3 == 0) ? 16'h0000 : 16'hffff);
    stop_sending();
  endtask

  // zero and oversized registers clamp; unused indexes change nothing
  task automatic test_clamps();
    set_geometry(9'h1ff, 0, 0, 5'h1f, 0, 0);
    for (int i = 0; i < 4; i++) send_sample(16'hffff);
    stop_sending();
    write_reg(REG_UNUSED_LO, 32'hffff_ffff);
    write_reg(REG_UNUSED_HI, 32'h0);
    for (int i = 0; i < 3; i++) send_sample(rand_sample());
    stop_sending();
    set_geometry(1, 1, 16'hffff, 16, 16, 16);
    for (int i = 0; i < 5; i++) send_sample(16'hffff);
    stop_sending();
  endtask

  task automatic test_random_volumes(int unsigned target);
    int unsigned sent, n, cnt;
    sent = 0;
    while (sent < target) begin
      tx_stall_on = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: set_geometry($urandom_range(0, 511), $urandom_range(0, 511),
                        $urandom_range(0, 16'hffff), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 31));
        1: set_geometry($urandom_range(1, 2), $urandom_range(1, 2), 1,
                        $urandom_range(8, 16), $urandom_range(8, 16), $urandom_range(1, 3));
        default: set_geometry($urandom_range(1, 6), $urandom_range(1, 6),
                              $urandom_range(1, 3), $urandom_range(1, 4),
                              $urandom_range(1, 4), $urandom_range(1, 4));
      endcase
      n = raster_size();
      cnt = (n <= 200) ? n + $urandom_range(0, n / 2) : $urandom_range(20, 200);
      for (int i = 0; i < cnt && sent < target; i++) begin
        send_sample(rand_sample());
        sent++;
      end
      stop_sending();
      if ($urandom_range(0, 4) == 0) begin
        // unused index while idle mid-volume
        write_reg(REG_UNUSED_LO, $urandom);
        for (int i = 0; i < 10 && sent < target; i++) begin
          send_sample(rand_sample());
          sent++;
        end
        stop_sending();
      end
    end
  endtask

  // result checker
  initial begin
    sum_result_t exp_r;
    int unsigned stall;
    m_axis_tready <= 1'b0;
    forever begin
      stall = rx_stall_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && !rst));
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected result", 0, m_axis_tdata);
      end else begin
        exp_r = expected_sums.pop_front();
        if (m_axis_tdata != {{(32-OUTW){1'b0}}, exp_r.window_sum})
          report_mismatch("window_sum", exp_r.window_sum, m_axis_tdata);
        if (m_axis_tuser[0] != exp_r.row_end)
          report_mismatch("row_end", exp_r.row_end, m_axis_tuser[0]);
        if (m_axis_tuser[1] != exp_r.volume_end)
          report_mismatch("volume_end", exp_r.volume_end, m_axis_tuser[1]);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    errors = 0;
    rx_stall_on = 1'b1;
    tx_stall_on = 1'b1;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cfg_in_width = 1;
    cfg_in_height = 1;
    cfg_in_depth = 1;
    cfg_win_x = 1;
    cfg_win_y = 1;
    cfg_win_z = 1;
    restart_volume();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_volume();
    test_clamps();
    test_random_volumes(1420);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bs3_pkg.sv
rtl/core/bs3_cfg.sv
rtl/core/bs3_row.sv
rtl/core/bs3_col.sv
rtl/core/bs3_plane.sv
rtl/core/box_sum_3d_full.sv
sim/tb_box_sum_3d_full.sv
